// ===== hdl/stack_machine_execute_unit_core_assert.svh =====
// assertion macros for the stack machine execute unit
`ifndef STACK_MACHINE_EXECUTE_UNIT_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/smx_pkg.sv =====
// shared types and constants for the stack machine execute unit
`timescale 1ns / 1ps
package smx_pkg;
    localparam int STACK_DEPTH = 256;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int NUM_REGS = 13;

    localparam logic [4:0] F_NOP = 5'd0;
    localparam logic [4:0] F_PUSH = 5'd1;
    localparam logic [4:0] F_POP = 5'd2;
    localparam logic [4:0] F_DUP = 5'd3;
    localparam logic [4:0] F_SWAP = 5'd4;
    localparam logic [4:0] F_SIZE = 5'd5;
    localparam logic [4:0] F_CLEAR = 5'd6;
    localparam logic [4:0] F_ADD = 5'd7;
    localparam logic [4:0] F_SUB = 5'd8;
    localparam logic [4:0] F_MUL = 5'd9;
    localparam logic [4:0] F_DIV = 5'd10;
    localparam logic [4:0] F_MOD = 5'd11;
    localparam logic [4:0] F_AND = 5'd12;
    localparam logic [4:0] F_OR = 5'd13;
    localparam logic [4:0] F_XOR = 5'd14;
    localparam logic [4:0] F_NOT = 5'd15;
    localparam logic [4:0] F_NEG = 5'd16;
    localparam logic [4:0] F_SHL = 5'd17;
    localparam logic [4:0] F_SHR = 5'd18;
    localparam logic [4:0] F_MOVE = 5'd19;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_OVER = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_DIVZ = 3'd3;
    localparam logic [2:0] ST_BADREG = 3'd4;

    typedef struct packed {
        logic       start;
        logic       is_mod;
        logic [31:0] a;
        logic [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;
endpackage

// ===== hdl/smx_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module smx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/smx_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle
`timescale 1ns / 1ps
module smx_div (
    input  logic                clk,
    input  logic                rst_n,
    input  smx_pkg::div_req_t   req,
    output smx_pkg::div_rsp_t   rsp
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        mod_reg, mod_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] shifted;
    logic [31:0] qfix, rfix;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        mod_next = mod_reg;
        done_next = 1'b0;
        shifted = {rem_reg[30:0], quo_reg[31]};
        trial = {1'b0, shifted} - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            rem_next = '0;
            quo_next = req.a[31] ? (32'd0 - req.a) : req.a;
            dvs_next = req.b[31] ? (32'd0 - req.b) : req.b;
            negq_next = req.a[31] ^ req.b[31];
            negr_next = req.a[31];
            mod_next = req.is_mod;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        mod_reg <= mod_next;
    end

    // min / -1 wraps naturally to min with remainder 0
    assign qfix = negq_reg ? (32'd0 - quo_reg) : quo_reg;
    assign rfix = negr_reg ? (32'd0 - rem_reg) : rem_reg;
    assign rsp.done = done_reg;
    assign rsp.result = mod_reg ? rfix : qfix;
endmodule

// ===== hdl/stack_machine_execute_unit_core.sv =====
// top level of the stack machine execute unit
//
// one instruction word enters on s_axis, one result word leaves on m_axis.
// s_axis_tdata: func, immediate, from_register, src_reg, dest_reg from bit 0
// m_axis_tdata: status, top_value, stack_depth from bit 0
// the stack lives in a single port ram with registered read, one access a cycle.
// after the accepting edge the block walks these states before m_axis_tvalid rises:
//   rd1, top, topw, out for push, size, clear, move, nop and any failing first check
//   rd1, rd1w, exec, top, topw, out for pop, dup, not, neg, shl and shr
//   rd1, rd1w, rd2, rd2w, exec, top, topw, out for add, sub, mul, and, or, xor
//   and div or mod with a zero divisor; swap adds wr2 after exec, and div and mod
//   add divw, waiting on the one bit per cycle divider (32 steps)
// the block takes one instruction at a time and is not ready while working
// or while its result word waits; a stalled receiver holds the result.
// s_axis_tready returns the cycle after the result handshake.
// reset empties the stack and zeroes the thirteen registers at once;
// stack entries need no clearing since only written entries are read.
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_core_assert.svh"
module stack_machine_execute_unit_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[4:0], immediate[68:5], from_register[69], src_reg[73:70], dest_reg[77:74]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], top_value[66:3], stack_depth[75:67]
    output logic [79:0]  m_axis_tdata
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1 = 4'd1;
    localparam logic [3:0] S_RD1W = 4'd2;
    localparam logic [3:0] S_RD2 = 4'd3;
    localparam logic [3:0] S_RD2W = 4'd4;
    localparam logic [3:0] S_EXEC = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_WR2 = 4'd7;
    localparam logic [3:0] S_TOP = 4'd8;
    localparam logic [3:0] S_TOPW = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    localparam int SPW = smx_pkg::SP_W;
    localparam int CW = smx_pkg::CNT_W;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0] regs_reg [smx_pkg::NUM_REGS];
    logic [4:0]  func_reg;
    logic [63:0] imm_reg;
    logic        fromr_reg;
    logic [3:0]  src_idx_reg, dst_idx_reg;
    logic [63:0] opb_reg, opb_next;
    logic [63:0] opa_reg, opa_next;
    logic [2:0]  status_reg, status_next;
    logic [63:0] top_reg, top_next;
    logic        outv_reg, outv_next;

    logic             ram_we;
    logic [SPW-1:0]   ram_addr;
    logic [63:0]      ram_wdata, ram_rdata;

    smx_pkg::div_req_t div_req;
    smx_pkg::div_rsp_t div_rsp;

    logic [4:0]  in_func;
    logic        accept;
    logic        reg_we;
    logic [3:0]  reg_wa;
    logic [63:0] reg_wd;
    logic [31:0] a32, b32, alu;
    logic [31:0] prod;
    logic        src_bad, dst_bad;
    logic        is_bin, is_un;
    logic        full;

    assign in_func = s_axis_tdata[4:0];
    assign s_axis_tready = (state_reg == S_IDLE) && !outv_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign full = (cnt_reg >= CW'(smx_pkg::STACK_DEPTH));
    assign src_bad = (src_idx_reg >= 4'(smx_pkg::NUM_REGS));
    assign dst_bad = (dst_idx_reg >= 4'(smx_pkg::NUM_REGS));
    assign is_bin = (func_reg >= smx_pkg::F_ADD) && (func_reg <= smx_pkg::F_XOR);
    assign is_un = (func_reg >= smx_pkg::F_NOT) && (func_reg <= smx_pkg::F_SHR);

    smx_ram #(.WIDTH(64), .DEPTH(smx_pkg::STACK_DEPTH)) u_stack (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    smx_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign a32 = opa_reg[31:0];
    assign b32 = opb_reg[31:0];
    assign prod = a32 * b32;

    always_comb
    begin
        unique case (func_reg)
            smx_pkg::F_ADD: alu = a32 + b32;
            smx_pkg::F_SUB: alu = a32 - b32;
            smx_pkg::F_MUL: alu = prod;
            smx_pkg::F_AND: alu = a32 & b32;
            smx_pkg::F_OR: alu = a32 | b32;
            smx_pkg::F_XOR: alu = a32 ^ b32;
            smx_pkg::F_NOT: alu = ~b32;
            smx_pkg::F_NEG: alu = 32'd0 - b32;
            smx_pkg::F_SHL: alu = b32 << imm_reg[4:0];
            smx_pkg::F_SHR: alu = 32'($signed(b32) >>> imm_reg[4:0]);
            default: alu = div_rsp.result;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        opb_next = opb_reg;
        opa_next = opa_reg;
        status_next = status_reg;
        top_next = top_reg;
        outv_next = outv_reg;
        ram_we = 1'b0;
        ram_addr = SPW'(cnt_reg - CW'(1));
        ram_wdata = opb_reg;
        reg_we = 1'b0;
        reg_wa = dst_idx_reg;
        reg_wd = opb_reg;
        div_req.start = 1'b0;
        div_req.is_mod = (func_reg == smx_pkg::F_MOD);
        div_req.a = a32;
        div_req.b = b32;
        if (outv_reg && m_axis_tready)
        begin
            outv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                status_next = smx_pkg::ST_OK;
                state_next = S_TOP;
                priority if (func_reg == smx_pkg::F_PUSH)
                begin
                    if (fromr_reg && src_bad)
                    begin
                        status_next = smx_pkg::ST_BADREG;
                    end
                    else if (full)
                    begin
                        status_next = smx_pkg::ST_OVER;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        ram_addr = SPW'(cnt_reg);
                        ram_wdata = fromr_reg ? regs_reg[src_idx_reg] : imm_reg;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else if (func_reg == smx_pkg::F_SIZE)
                begin
                    if (full)
                    begin
                        status_next = smx_pkg::ST_OVER;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        ram_addr = SPW'(cnt_reg);
                        ram_wdata = 64'(cnt_reg);
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else if (func_reg == smx_pkg::F_CLEAR)
                begin
                    cnt_next = '0;
                end
                else if (func_reg == smx_pkg::F_MOVE)
                begin
                    if (src_bad || dst_bad)
                    begin
                        status_next = smx_pkg::ST_BADREG;
                    end
                    else
                    begin
                        reg_we = 1'b1;
                        reg_wd = regs_reg[src_idx_reg];
                    end
                end
                else if (func_reg == smx_pkg::F_POP || func_reg == smx_pkg::F_DUP
                         || is_un)
                begin
                    if (cnt_reg == '0)
                    begin
                        status_next = smx_pkg::ST_UNDER;
                    end
                    else if (func_reg == smx_pkg::F_DUP && full)
                    begin
                        status_next = smx_pkg::ST_OVER;
                    end
                    else
                    begin
                        state_next = S_RD1W;
                    end
                end
                else if (is_bin || func_reg == smx_pkg::F_SWAP)
                begin
                    if (cnt_reg < CW'(2))
                    begin
                        status_next = smx_pkg::ST_UNDER;
                    end
                    else
                    begin
                        state_next = S_RD1W;
                    end
                end
                else
                begin
                    // nop and unknown codes
                    status_next = smx_pkg::ST_OK;
                end
            end
            S_RD1W:
            begin
                opb_next = ram_rdata;
                state_next = (is_bin || func_reg == smx_pkg::F_SWAP) ? S_RD2 : S_EXEC;
            end
            S_RD2:
            begin
                ram_addr = SPW'(cnt_reg - CW'(2));
                state_next = S_RD2W;
            end
            S_RD2W:
            begin
                ram_addr = SPW'(cnt_reg - CW'(2));
                opa_next = ram_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_TOP;
                priority if (func_reg == smx_pkg::F_POP)
                begin
                    reg_we = !dst_bad;
                    cnt_next = cnt_reg - CW'(1);
                end
                else if (func_reg == smx_pkg::F_DUP)
                begin
                    ram_we = 1'b1;
                    ram_addr = SPW'(cnt_reg);
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (func_reg == smx_pkg::F_SWAP)
                begin
                    ram_we = 1'b1;
                    ram_wdata = opa_reg;
                    state_next = S_WR2;
                end
                else if (is_un)
                begin
                    ram_we = 1'b1;
                    ram_wdata = {{32{alu[31]}}, alu};
                end
                else if (func_reg == smx_pkg::F_DIV || func_reg == smx_pkg::F_MOD)
                begin
                    if (b32 == 32'd0)
                    begin
                        status_next = smx_pkg::ST_DIVZ;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next = S_DIVW;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                    ram_addr = SPW'(cnt_reg - CW'(2));
                    ram_wdata = {{32{alu[31]}}, alu};
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    ram_we = 1'b1;
                    ram_addr = SPW'(cnt_reg - CW'(2));
                    ram_wdata = {{32{alu[31]}}, alu};
                    cnt_next = cnt_reg - CW'(1);
                    state_next = S_TOP;
                end
            end
            S_WR2:
            begin
                ram_we = 1'b1;
                ram_addr = SPW'(cnt_reg - CW'(2));
                ram_wdata = opb_reg;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                top_next = (cnt_reg == '0) ? 64'd0 : ram_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                outv_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            outv_reg <= 1'b0;
            for (int i = 0; i < smx_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            outv_reg <= outv_next;
            if (reg_we)
            begin
                regs_reg[reg_wa] <= reg_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= in_func;
            imm_reg <= s_axis_tdata[68:5];
            fromr_reg <= s_axis_tdata[69];
            src_idx_reg <= s_axis_tdata[73:70];
            dst_idx_reg <= s_axis_tdata[77:74];
        end
        opb_reg <= opb_next;
        opa_reg <= opa_next;
        status_reg <= status_next;
        top_reg <= top_next;
    end

    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata = {4'd0, 9'(cnt_reg), top_reg, status_reg};

    `SMX_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_axis_tready)
    `SMX_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(smx_pkg::STACK_DEPTH))
    `SMX_ASSERT_NEXT(a_out_after, clk, rst_n, state_reg == S_OUT, m_axis_tvalid)
    `SMX_ASSERT_IMPL(a_div_only_wait, clk, rst_n, div_rsp.done, state_reg == S_DIVW)
endmodule
